/* rtl/pcld_pkg.sv */
// Shared types, constants and decode helpers of the pin command line decoder.
// No dependencies; all other files import this package.
package pcld_pkg;

	localparam int ADC_WIDTH_DEF = 10;
	localparam int LINE_KEEP     = 5;
	localparam int POS_W         = 3;
	localparam int SEGMENT_PINS  = 8;
	localparam int SEG_IDX_W     = 3;
	localparam int CMDQ_DEPTH    = 4;
	localparam int BCD_DIGITS    = 5;
	localparam int DIG_IDX_W     = 3;

	// character codes
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [1:0] {
		ACT_PIN  = 2'd0,
		ACT_PWM  = 2'd1,
		ACT_CHAR = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		CMD_WD,
		CMD_WA,
		CMD_WH,
		CMD_RD,
		CMD_RA
	} cmd_kind_t;

	// decoded command; arg is level, duty, segment code or response char
	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  pin;
		logic [7:0]  arg;
	} cmd_t;

	// common-anode seven-segment codes, hex digits 0..F
	localparam logic [7:0] SEG_CODES [16] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
	};

	// floor(255*d/9) for d = 0..9
	localparam logic [7:0] DUTY_TABLE [10] = '{
		8'd0, 8'd28, 8'd56, 8'd85, 8'd113, 8'd141, 8'd170, 8'd198, 8'd226, 8'd255
	};

	function automatic logic [3:0] dec_val(input logic [7:0] c);
		logic [3:0] r;
		r = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			r = c[3:0];
		end
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] r;
		r = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			r = c[3:0];
		end else if (c >= CH_A && c <= CH_F) begin
			r = 4'(c[3:0] + 4'd9);
		end
		return r;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LC_A && c <= CH_LC_Z) begin
			r = c & ~CASE_BIT;
		end
		return r;
	endfunction

endpackage

/* rtl/pcld_ifs.sv */
// Valid/ready channel interfaces of the pin command line decoder.
// Depends on pcld_pkg.
interface pcld_cmd_if import pcld_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [7:0]           char_in;
	logic                 button_level;
	logic [ADC_WIDTH-1:0] adc_sample;

	modport source(output valid, char_in, button_level, adc_sample, input ready);
	modport sink(input valid, char_in, button_level, adc_sample, output ready);
endinterface

interface pcld_rsp_if import pcld_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [6:0] pin;
	logic [7:0] value;
	logic       last;

	modport source(output valid, action, pin, value, last, input ready);
	modport sink(input valid, action, pin, value, last, output ready);
endinterface

/* rtl/pin_command_line_decoder_core.sv */
// Top level of the pin command line decoder: front end, command queue, back end.
// Depends on pcld_pkg, pcld_ifs, pcld_front, pcld_cmd_fifo, pcld_back.
//
//   channel | dir | payload                               | transfer when
//   --------+-----+---------------------------------------+------------------
//   cmd     | in  | char_in, button_level, adc_sample     | cmd.valid & ready
//   rsp     | out | action, pin, value, last              | rsp.valid & ready
//
// One byte per cycle is taken while the command queue has room; ordinary bytes
// only fill the five-character line buffer. A newline decodes the line in the
// same cycle and queues a valid command (button and ADC are sampled then).
// The back end issues one result per cycle while rsp is ready: a single-result
// command is registered on its pop, WH gives eight back-to-back transfers, and RA
// shifts every ADC bit through the shift-add-3 BCD unit, then makes one
// transfer per digit. Reset clears the line buffer, queue and back end at once.
// A stalled rsp holds the output register; the queue absorbs newlines until full,
// after which cmd.ready drops.
module pin_command_line_decoder_core import pcld_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pcld_cmd_if.sink    cmd,
	pcld_rsp_if.source  rsp
);

	localparam int QW = $bits(cmd_t) + ADC_WIDTH;

	// front -> queue
	logic                 push;
	cmd_t                 push_cmd;
	logic [ADC_WIDTH-1:0] push_adc;
	logic                 q_full;

	// queue -> back
	logic                 pop;
	logic                 q_empty;
	logic [QW-1:0]        q_data;
	cmd_t                 q_cmd;
	logic [ADC_WIDTH-1:0] q_adc;

	assign {q_cmd, q_adc} = q_data;

	pcld_front #(
		.ADC_WIDTH (ADC_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.push_adc (push_adc)
	);

	pcld_cmd_fifo #(
		.DATA_W (QW),
		.DEPTH  (CMDQ_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_cmd, push_adc}),
		.pop     (pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	pcld_back #(
		.ADC_WIDTH (ADC_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (q_cmd),
		.q_adc   (q_adc),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

/* rtl/pcld_front.sv */
// Front end: line buffer with case folding, command decode on newline.
// Depends on pcld_pkg and pcld_ifs.
module pcld_front import pcld_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pcld_cmd_if.sink             cmd,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd,
	output logic [ADC_WIDTH-1:0] push_adc
);

	logic [7:0]       line_q [LINE_KEEP];
	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic             is_nl;
	logic             cmd_ok;
	logic [3:0]       d_hi;
	logic [3:0]       d_lo;
	logic [6:0]       pin;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign is_nl     = (cmd.char_in == CH_NL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < LINE_KEEP; i++) begin
				line_q[i] <= '0;
			end
		end else if (accept) begin
			if (is_nl) begin
				pos_q <= '0;
				for (int i = 0; i < LINE_KEEP; i++) begin
					line_q[i] <= '0;
				end
			end else if (pos_q < POS_W'(LINE_KEEP)) begin
				line_q[pos_q] <= fold_case(cmd.char_in);
				pos_q         <= pos_q + POS_W'(1);
			end
		end
	end

	// pin = 10*tens + ones, as shift-add
	assign d_hi = dec_val(line_q[2]);
	assign d_lo = dec_val(line_q[3]);
	assign pin  = 7'({d_hi, 3'b000}) + 7'({d_hi, 1'b0}) + 7'(d_lo);

	always_comb begin
		cmd_ok        = 1'b0;
		push_cmd.kind = CMD_WD;
		push_cmd.pin  = pin;
		push_cmd.arg  = '0;
		if (line_q[0] == CH_W) begin
			if (line_q[1] == CH_D) begin
				if (line_q[4] == CH_H) begin
					cmd_ok       = 1'b1;
					push_cmd.arg = 8'd1;
				end else if (line_q[4] == CH_L) begin
					cmd_ok       = 1'b1;
				end
			end else if (line_q[1] == CH_A) begin
				cmd_ok        = 1'b1;
				push_cmd.kind = CMD_WA;
				push_cmd.arg  = DUTY_TABLE[dec_val(line_q[4])];
			end else if (line_q[1] == CH_H) begin
				cmd_ok        = 1'b1;
				push_cmd.kind = CMD_WH;
				push_cmd.arg  = SEG_CODES[hex_val(line_q[4])];
			end
		end else if (line_q[0] == CH_R) begin
			if (line_q[1] == CH_D) begin
				cmd_ok        = 1'b1;
				push_cmd.kind = CMD_RD;
				push_cmd.pin  = '0;
				push_cmd.arg  = cmd.button_level ? CH_H : CH_L;
			end else if (line_q[1] == CH_A) begin
				cmd_ok        = 1'b1;
				push_cmd.kind = CMD_RA;
				push_cmd.pin  = '0;
			end
		end
	end

	assign push     = accept && is_nl && cmd_ok;
	assign push_adc = cmd.adc_sample;

endmodule

/* rtl/pcld_cmd_fifo.sv */
// Small command queue between front and back end.
// Depends on pcld_pkg.
module pcld_cmd_fifo import pcld_pkg::*; #(
	parameter int DATA_W = $bits(cmd_t) + ADC_WIDTH_DEF,
	parameter int DEPTH  = CMDQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              pop,
	output logic [DATA_W-1:0] rd_data,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("command queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty) else $error("queue empty after a lone push");

endmodule

/* rtl/pcld_back.sv */
// Back end: expands queued commands into result transfers, with an
// iterative binary-to-BCD unit for the analog read. Depends on pcld_pkg, pcld_ifs.
module pcld_back import pcld_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  cmd_t                 q_cmd,
	input  logic [ADC_WIDTH-1:0] q_adc,
	output logic                 pop,
	pcld_rsp_if.source           rsp
);

	localparam int BITS_W = $clog2(ADC_WIDTH + 1);
	localparam int BCD_W  = 4 * BCD_DIGITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEG,
		ST_CONV,
		ST_DIGITS
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [SEG_IDX_W-1:0] seg_idx_q;
	logic [ADC_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BITS_W-1:0]    bit_cnt_q;
	logic [DIG_IDX_W-1:0] dig_q;

	logic       out_valid_q;
	action_t    out_action_q;
	logic [6:0] out_pin_q;
	logic [7:0] out_value_q;
	logic       out_last_q;

	logic                 out_free;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BCD_W-1:0]     bcd_n;
	logic [DIG_IDX_W-1:0] msd;

	assign out_free = !out_valid_q || rsp.ready;
	assign pop      = (state_q == ST_IDLE) && !q_empty && out_free;

	assign rsp.valid  = out_valid_q;
	assign rsp.action = out_action_q;
	assign rsp.pin    = out_pin_q;
	assign rsp.value  = out_value_q;
	assign rsp.last   = out_last_q;

	// one double-dabble step: add 3 to digits >= 5, then shift in next bit
	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
		bcd_n = {bcd_adj[BCD_W-2:0], bin_q[ADC_WIDTH-1]};
		msd   = '0;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (bcd_n[4*d +: 4] != 4'd0) begin
				msd = DIG_IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_action_q <= ACT_PIN;
			out_pin_q    <= '0;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
			cmd_q        <= '0;
			seg_idx_q    <= '0;
			bin_q        <= '0;
			bcd_q        <= '0;
			bit_cnt_q    <= '0;
			dig_q        <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cmd_q <= q_cmd;
						unique case (q_cmd.kind)
							CMD_WD, CMD_WA, CMD_RD: begin
								out_valid_q  <= 1'b1;
								out_action_q <= (q_cmd.kind == CMD_WD) ? ACT_PIN :
									(q_cmd.kind == CMD_WA) ? ACT_PWM : ACT_CHAR;
								out_pin_q    <= q_cmd.pin;
								out_value_q  <= q_cmd.arg;
								out_last_q   <= 1'b1;
							end
							CMD_WH: begin
								out_valid_q  <= 1'b1;
								out_action_q <= ACT_PIN;
								out_pin_q    <= q_cmd.pin;
								out_value_q  <= {7'b0, q_cmd.arg[0]};
								out_last_q   <= 1'b0;
								seg_idx_q    <= SEG_IDX_W'(1);
								state_q      <= ST_SEG;
							end
							CMD_RA: begin
								bin_q     <= q_adc;
								bcd_q     <= '0;
								bit_cnt_q <= BITS_W'(ADC_WIDTH);
								state_q   <= ST_CONV;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEG: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_action_q <= ACT_PIN;
						out_pin_q    <= cmd_q.pin + 7'(seg_idx_q);
						out_value_q  <= {7'b0, cmd_q.arg[seg_idx_q]};
						out_last_q   <= (seg_idx_q == SEG_IDX_W'(SEGMENT_PINS - 1));
						seg_idx_q    <= seg_idx_q + SEG_IDX_W'(1);
						if (seg_idx_q == SEG_IDX_W'(SEGMENT_PINS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CONV: begin
					bcd_q     <= bcd_n;
					bin_q     <= bin_q << 1;
					bit_cnt_q <= bit_cnt_q - BITS_W'(1);
					if (bit_cnt_q == BITS_W'(1)) begin
						dig_q   <= msd;
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_action_q <= ACT_CHAR;
						out_pin_q    <= '0;
						out_value_q  <= CH_0 | {4'b0, bcd_q[4*dig_q +: 4]};
						out_last_q   <= (dig_q == '0);
						dig_q        <= dig_q - DIG_IDX_W'(1);
						if (dig_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_seg_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEG |-> seg_idx_q != '0) else $error("segment index restarted");
	a_dig_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGITS |-> dig_q < DIG_IDX_W'(BCD_DIGITS))
		else $error("digit index out of range");
	a_conv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> bit_cnt_q != '0) else $error("conversion count ran out");
	a_seg_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEG && out_free) |=> out_valid_q)
		else $error("segment transfer not loaded");

endmodule
